### rtl/pa_pkg.sv
// Shared constants, types and vertex-order function for the primitive assembler.
`default_nettype none
package pa_pkg;

   // topology codes
   localparam logic [3:0] TOPO_TRILIST   = 4'd0;
   localparam logic [3:0] TOPO_TRISTRIP  = 4'd1;
   localparam logic [3:0] TOPO_TRIFAN    = 4'd2;
   localparam logic [3:0] TOPO_POLYGON   = 4'd3;
   localparam logic [3:0] TOPO_QUADLIST  = 4'd4;
   localparam logic [3:0] TOPO_QUADSTRIP = 4'd5;
   localparam logic [3:0] TOPO_RECTLIST  = 4'd6;
   localparam logic [3:0] TOPO_LINELIST  = 4'd7;
   localparam logic [3:0] TOPO_LINESTRIP = 4'd8;
   localparam logic [3:0] TOPO_LINELOOP  = 4'd9;

   // register indexes
   localparam logic [1:0] REG_TOPOLOGY        = 2'd0;
   localparam logic [1:0] REG_STRIP_PROVOKING = 2'd1;
   localparam logic [1:0] REG_FAN_PROVOKING   = 2'd2;

   // input item kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_END    = 1'b1;

   localparam int WIN_DEPTH  = 4;
   localparam int FIFO_DEPTH = 4;

   localparam logic [1:0] ROT_TAB [5] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1};

   // push request into the result queue; push_b only ever with push_a
   typedef struct packed {
      logic push_a;
      logic push_b;
   } pa_push_type;

   // corner order {a, b, c} for a triangle, with provoking rotation and winding
   function automatic logic [5:0] pa_tri_order(input logic [1:0] prov, input logic par);
      logic [2:0] p;
      logic [2:0] ib;
      logic [2:0] ic;
      p  = (prov > 2'd2) ? 3'd2 : {1'b0, prov};
      ib = p + 3'd1 + {2'b0, par};
      ic = p + 3'd2 - {2'b0, par};
      return {ROT_TAB[p], ROT_TAB[ib], ROT_TAB[ic]};
   endfunction

endpackage
`default_nettype wire

### rtl/pa_out_fifo.sv
// Four-entry result queue taking up to two pushes and one pop per cycle.
`default_nettype none
module pa_out_fifo
   import pa_pkg::*;
#(
   parameter int DATA_WIDTH = 50
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pa_push_type           push,
   input  wire logic [DATA_WIDTH-1:0] push_data_a,
   input  wire logic [DATA_WIDTH-1:0] push_data_b,
   input  wire logic                  pop,
   output logic                       out_valid,
   output logic [DATA_WIDTH-1:0]      out_data,
   output logic                       room
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [DATA_WIDTH-1:0] data_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = data_ff[rd_ptr_ff];
   // space for the two results one transaction can make
   assign room      = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push_a) + PTR_W'(push.push_b);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push.push_a) + CNT_W'(push.push_b) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         data_ff[wr_ptr_ff] <= push_data_a;
      end
      if (push.push_b) begin
         data_ff[wr_ptr_ff + PTR_W'(1)] <= push_data_b;
      end
   end

endmodule
`default_nettype wire

### rtl/primitive_assembler.sv
// Top level of the primitive assembler: vertex window, assembly logic and CSRs.
`default_nettype none
// Builds triangles and lines from a stream of shaded vertices. One input
// transaction (a vertex or an end-of-instance marker) is taken per cycle while
// req_stall is low; the assembly state (vertex window, anchor, strip parity) is
// updated in the cycle of acceptance and the results land in a four-entry result
// queue, so rsp_valid rises in the cycle after the transaction that made them.
// The queue drains one result per cycle while rsp_stall is low, and req_stall
// rises while it holds more than two, so a transaction that makes two triangles
// (quad lists and quad strips) can hold the input when results are not taken
// fast enough. Primitives with a clipped corner are discarded; last_of_run marks the
// final result of each transaction. Configuration (topology, provoking vertices)
// sits behind an APB port at byte addresses 0, 4 and 8; the user must see that it is
// written only while the block is idle, which the block does not enforce. An
// end-of-instance transaction clears the assembly state but keeps the registers.
module primitive_assembler
   import pa_pkg::*;
#(
   parameter int HANDLE_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input transactions
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [HANDLE_WIDTH-1:0] req_vertex_handle,
   input  wire logic                    req_vertex_clipped,
   input  wire logic [31:0]             req_pos_x_bits,
   input  wire logic [31:0]             req_pos_y_bits,
   // result transactions
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [HANDLE_WIDTH-1:0]      rsp_corner_a,
   output logic [HANDLE_WIDTH-1:0]      rsp_corner_b,
   output logic [HANDLE_WIDTH-1:0]      rsp_corner_c,
   output logic                         rsp_is_line,
   output logic                         rsp_last_of_run,
   // configuration
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [3:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int RES_W = 3 * HANDLE_WIDTH + 2;

   // ---------------------------------------------------------------- CSRs
   logic [3:0] topology_ff;
   logic [1:0] strip_prov_ff;
   logic [1:0] fan_prov_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff   <= TOPO_TRILIST;
         strip_prov_ff <= '0;
         fan_prov_ff   <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_TOPOLOGY:        topology_ff   <= pwdata[3:0];
            REG_STRIP_PROVOKING: strip_prov_ff <= pwdata[1:0];
            REG_FAN_PROVOKING:   fan_prov_ff   <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TOPOLOGY:        prdata = {28'b0, topology_ff};
         REG_STRIP_PROVOKING: prdata = {30'b0, strip_prov_ff};
         REG_FAN_PROVOKING:   prdata = {30'b0, fan_prov_ff};
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------ assembly state
   logic [HANDLE_WIDTH-1:0] win_h_ff  [WIN_DEPTH];
   logic                    win_cl_ff [WIN_DEPTH];
   logic [31:0]             win_x_ff  [WIN_DEPTH];
   logic [31:0]             win_y_ff  [WIN_DEPTH];
   logic [HANDLE_WIDTH-1:0] win_h_in  [WIN_DEPTH];
   logic                    win_cl_in [WIN_DEPTH];
   logic [31:0]             win_x_in  [WIN_DEPTH];
   logic [31:0]             win_y_in  [WIN_DEPTH];
   logic [2:0]              fill_ff, fill_in;
   logic [HANDLE_WIDTH-1:0] anc_h_ff, anc_h_in;
   logic                    anc_cl_ff, anc_cl_in;
   logic                    anc_valid_ff, anc_valid_in;
   logic                    parity_ff, parity_in;

   // window after pushing the incoming vertex (oldest dropped when full)
   logic [HANDLE_WIDTH-1:0] wp_h  [WIN_DEPTH];
   logic                    wp_cl [WIN_DEPTH];
   logic [31:0]             wp_x  [WIN_DEPTH];
   logic [31:0]             wp_y  [WIN_DEPTH];
   logic [2:0]              wp_fill;
   logic                    win_full;
   logic [1:0]              push_pos;
   logic [1:0]              rect_rot;

   logic req_accept;
   logic queue_room;

   assign req_stall  = !queue_room;
   assign req_accept = req_valid && queue_room;

   assign win_full = (fill_ff >= 3'(WIN_DEPTH));
   assign push_pos = win_full ? 2'(WIN_DEPTH - 1) : fill_ff[1:0];
   assign wp_fill  = win_full ? 3'(WIN_DEPTH) : fill_ff + 3'd1;

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (win_full && i < WIN_DEPTH - 1) begin
            wp_h[i]  = win_h_ff[i+1];
            wp_cl[i] = win_cl_ff[i+1];
            wp_x[i]  = win_x_ff[i+1];
            wp_y[i]  = win_y_ff[i+1];
         end else begin
            wp_h[i]  = win_h_ff[i];
            wp_cl[i] = win_cl_ff[i];
            wp_x[i]  = win_x_ff[i];
            wp_y[i]  = win_y_ff[i];
         end
         if (push_pos == 2'(i)) begin
            wp_h[i]  = req_vertex_handle;
            wp_cl[i] = req_vertex_clipped;
            wp_x[i]  = req_pos_x_bits;
            wp_y[i]  = req_pos_y_bits;
         end
      end
   end

   // rect list: rotate so that the middle corner (b) faces the hypotenuse
   always_comb begin
      if (wp_x[0] != wp_x[1] && wp_y[0] != wp_y[1]) begin
         rect_rot = 2'd1;
      end else if (wp_x[1] != wp_x[2] && wp_y[1] != wp_y[2]) begin
         rect_rot = 2'd2;
      end else begin
         rect_rot = 2'd0;
      end
   end

   // primitive candidates: two triangles and one line
   logic [HANDLE_WIDTH-1:0] t0_h  [3];
   logic                    t0_cl [3];
   logic [1:0]              t0_prov;
   logic                    t0_par;
   logic                    t0_en;
   logic [HANDLE_WIDTH-1:0] t1_h  [3];
   logic                    t1_cl [3];
   logic                    t1_en;
   logic [HANDLE_WIDTH-1:0] ln_h0, ln_h1;
   logic                    ln_c0, ln_c1;
   logic                    ln_en;
   logic                    do_drop;
   logic [2:0]              drop_k;
   logic                    anchor_only;

   always_comb begin
      fill_in      = fill_ff;
      anc_h_in     = anc_h_ff;
      anc_cl_in    = anc_cl_ff;
      anc_valid_in = anc_valid_ff;
      parity_in    = parity_ff;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_h_in[i]  = win_h_ff[i];
         win_cl_in[i] = win_cl_ff[i];
         win_x_in[i]  = win_x_ff[i];
         win_y_in[i]  = win_y_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         t0_h[i]  = wp_h[i];
         t0_cl[i] = wp_cl[i];
         t1_h[i]  = wp_h[3];
         t1_cl[i] = wp_cl[3];
      end
      t0_prov     = '0;
      t0_par      = 1'b0;
      t0_en       = 1'b0;
      t1_en       = 1'b0;
      ln_h0       = wp_h[0];
      ln_c0       = wp_cl[0];
      ln_h1       = wp_h[1];
      ln_c1       = wp_cl[1];
      ln_en       = 1'b0;
      do_drop     = 1'b0;
      drop_k      = '0;
      anchor_only = 1'b0;

      if (req_kind == KIND_END) begin
         // close an open line loop back to its first vertex
         if (topology_ff == TOPO_LINELOOP && fill_ff == 3'd1 && anc_valid_ff) begin
            ln_en = 1'b1;
            ln_h0 = win_h_ff[0];
            ln_c0 = win_cl_ff[0];
            ln_h1 = anc_h_ff;
            ln_c1 = anc_cl_ff;
         end
         fill_in      = '0;
         anc_h_in     = '0;
         anc_cl_in    = 1'b0;
         anc_valid_in = 1'b0;
         parity_in    = 1'b0;
      end else if (topology_ff <= TOPO_LINELOOP) begin
         if (!anc_valid_ff && (topology_ff == TOPO_TRIFAN || topology_ff == TOPO_POLYGON
                               || topology_ff == TOPO_LINELOOP)) begin
            anc_h_in     = req_vertex_handle;
            anc_cl_in    = req_vertex_clipped;
            anc_valid_in = 1'b1;
            // fan and polygon anchors stay out of the window
            anchor_only  = (topology_ff != TOPO_LINELOOP);
         end
         if (!anchor_only) begin
            win_h_in  = wp_h;
            win_cl_in = wp_cl;
            win_x_in  = wp_x;
            win_y_in  = wp_y;
            fill_in   = wp_fill;
            case (topology_ff)
               TOPO_TRILIST: begin
                  if (wp_fill >= 3'd3) begin
                     t0_en   = 1'b1;
                     t0_prov = strip_prov_ff;
                     do_drop = 1'b1;
                     drop_k  = 3'd3;
                  end
               end
               TOPO_TRISTRIP: begin
                  if (wp_fill >= 3'd3) begin
                     t0_en     = 1'b1;
                     t0_prov   = strip_prov_ff;
                     t0_par    = parity_ff;
                     parity_in = !parity_ff;
                     do_drop   = 1'b1;
                     drop_k    = 3'd1;
                  end
               end
               TOPO_TRIFAN, TOPO_POLYGON: begin
                  if (wp_fill >= 3'd2) begin
                     t0_en    = 1'b1;
                     t0_h[0]  = anc_h_ff;
                     t0_cl[0] = anc_cl_ff;
                     t0_h[1]  = wp_h[0];
                     t0_cl[1] = wp_cl[0];
                     t0_h[2]  = wp_h[1];
                     t0_cl[2] = wp_cl[1];
                     t0_prov  = (topology_ff == TOPO_TRIFAN) ? fan_prov_ff : 2'd0;
                     t0_par   = parity_ff;
                     do_drop  = 1'b1;
                     drop_k   = 3'd1;
                  end
               end
               TOPO_QUADLIST, TOPO_QUADSTRIP: begin
                  if (wp_fill >= 3'd4) begin
                     t0_en    = 1'b1;
                     t1_en    = 1'b1;
                     t0_h[0]  = wp_h[3];
                     t0_cl[0] = wp_cl[3];
                     t0_h[1]  = wp_h[0];
                     t0_cl[1] = wp_cl[0];
                     t0_h[2]  = wp_h[1];
                     t0_cl[2] = wp_cl[1];
                     do_drop  = 1'b1;
                     if (topology_ff == TOPO_QUADLIST) begin
                        t1_h[1]  = wp_h[1];
                        t1_cl[1] = wp_cl[1];
                        t1_h[2]  = wp_h[2];
                        t1_cl[2] = wp_cl[2];
                        drop_k   = 3'd4;
                     end else begin
                        t1_h[1]  = wp_h[2];
                        t1_cl[1] = wp_cl[2];
                        t1_h[2]  = wp_h[0];
                        t1_cl[2] = wp_cl[0];
                        drop_k   = 3'd2;
                     end
                  end
               end
               TOPO_RECTLIST: begin
                  if (wp_fill >= 3'd3) begin
                     t0_en   = 1'b1;
                     t0_prov = rect_rot;
                     do_drop = 1'b1;
                     drop_k  = 3'd3;
                  end
               end
               default: begin
                  // line list, strip and loop
                  if (wp_fill >= 3'd2) begin
                     ln_en   = 1'b1;
                     do_drop = 1'b1;
                     drop_k  = (topology_ff == TOPO_LINELIST) ? 3'd2 : 3'd1;
                  end
               end
            endcase
            if (do_drop) begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  if (3'(i) + drop_k < 3'(WIN_DEPTH)) begin
                     win_h_in[i]  = wp_h[2'(3'(i) + drop_k)];
                     win_cl_in[i] = wp_cl[2'(3'(i) + drop_k)];
                     win_x_in[i]  = wp_x[2'(3'(i) + drop_k)];
                     win_y_in[i]  = wp_y[2'(3'(i) + drop_k)];
                  end
               end
               fill_in = (drop_k >= wp_fill) ? 3'd0 : wp_fill - drop_k;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         anc_h_ff     <= '0;
         anc_cl_ff    <= 1'b0;
         anc_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
      end else if (req_accept) begin
         fill_ff      <= fill_in;
         anc_h_ff     <= anc_h_in;
         anc_cl_ff    <= anc_cl_in;
         anc_valid_ff <= anc_valid_in;
         parity_ff    <= parity_in;
      end
   end

   // window payload, no reset: entries are written before they are read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         win_h_ff  <= win_h_in;
         win_cl_ff <= win_cl_in;
         win_x_ff  <= win_x_in;
         win_y_ff  <= win_y_in;
      end
   end

   // ------------------------------------------------- result formation
   logic [5:0]              t0_ord;
   logic [5:0]              t1_ord;
   logic                    r0_ok, r1_ok;
   logic [HANDLE_WIDTH-1:0] r0_a, r0_b, r0_c;
   logic                    r0_line;
   logic [HANDLE_WIDTH-1:0] r1_a, r1_b, r1_c;
   pa_push_type             push;
   logic [RES_W-1:0]        push_data_a, push_data_b;
   logic [RES_W-1:0]        out_data;

   assign t0_ord = pa_tri_order(t0_prov, t0_par);
   // quad triangles: provoking zero, no winding flip
   assign t1_ord = pa_tri_order(2'd0, 1'b0);

   always_comb begin
      if (ln_en) begin
         r0_ok   = !(ln_c0 || ln_c1);
         r0_a    = ln_h0;
         r0_b    = ln_h1;
         r0_c    = '0;
         r0_line = 1'b1;
      end else begin
         r0_ok   = t0_en && !(t0_cl[0] || t0_cl[1] || t0_cl[2]);
         r0_a    = t0_h[t0_ord[5:4]];
         r0_b    = t0_h[t0_ord[3:2]];
         r0_c    = t0_h[t0_ord[1:0]];
         r0_line = 1'b0;
      end
      r1_ok = t1_en && !(t1_cl[0] || t1_cl[1] || t1_cl[2]);
      r1_a  = t1_h[t1_ord[5:4]];
      r1_b  = t1_h[t1_ord[3:2]];
      r1_c  = t1_h[t1_ord[1:0]];
   end

   // compact the surviving results; last_of_run goes on the final one
   always_comb begin
      push.push_a = req_accept && (r0_ok || r1_ok);
      push.push_b = req_accept && r0_ok && r1_ok;
      if (r0_ok) begin
         push_data_a = {r0_a, r0_b, r0_c, r0_line, !r1_ok};
      end else begin
         push_data_a = {r1_a, r1_b, r1_c, 1'b0, 1'b1};
      end
      push_data_b = {r1_a, r1_b, r1_c, 1'b0, 1'b1};
   end

   pa_out_fifo #(
      .DATA_WIDTH (RES_W)
   ) u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data_a (push_data_a),
      .push_data_b (push_data_b),
      .pop         (!rsp_stall),
      .out_valid   (rsp_valid),
      .out_data    (out_data),
      .room        (queue_room)
   );

   assign rsp_corner_a    = out_data[RES_W-1 -: HANDLE_WIDTH];
   assign rsp_corner_b    = out_data[2*HANDLE_WIDTH+1 -: HANDLE_WIDTH];
   assign rsp_corner_c    = out_data[HANDLE_WIDTH+1 -: HANDLE_WIDTH];
   assign rsp_is_line     = out_data[1];
   assign rsp_last_of_run = out_data[0];

endmodule
`default_nettype wire

### test/primitive_assembler_test.sv
// Self-checking testbench for the primitive assembler: predictor, stimulus and result checks.
module primitive_assembler_test;
   import pa_pkg::*;

   // Run limits. The cycle limit leaves plenty of margin for the slowest correct
   // run (every transaction waiting out receiver stalls and the long hold-off).
   localparam int LIMIT_CYCLES  = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int ITEM_TARGET   = 1200;
   localparam int QUIET_CYCLES  = 8;
   localparam int IDLE_PERCENT  = 21;
   localparam int HOLD_CYCLES   = 80;
   localparam int CLIP_PERCENT  = 8;

   // highest topology code the register holds; codes above line loop are unused
   localparam logic [3:0] TOPO_UNUSED_TOP = 4'd15;

   typedef logic [15:0] handle_type;

   typedef struct {
      handle_type corner_a;
      handle_type corner_b;
      handle_type corner_c;
      logic       is_line;
      logic       last_of_run;
   } prim_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic          clock = 1'b0;
   logic          reset = 1'b1;

   logic          req_valid          = 1'b0;
   logic          req_stall;
   logic          req_kind           = KIND_VERTEX;
   handle_type    req_vertex_handle  = '0;
   logic          req_vertex_clipped = 1'b0;
   logic [31:0]   req_pos_x_bits     = '0;
   logic [31:0]   req_pos_y_bits     = '0;

   logic          rsp_valid;
   logic          rsp_stall          = 1'b0;
   handle_type    rsp_corner_a;
   handle_type    rsp_corner_b;
   handle_type    rsp_corner_c;
   logic          rsp_is_line;
   logic          rsp_last_of_run;

   logic          psel               = 1'b0;
   logic          penable            = 1'b0;
   logic          pwrite             = 1'b0;
   logic [3:0]    paddr              = '0;
   logic [31:0]   pwdata             = '0;
   logic [31:0]   prdata;
   logic          pready;

   always #6 clock = ~clock;

   primitive_assembler #(
      .HANDLE_WIDTH(16)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_vertex_handle  (req_vertex_handle),
      .req_vertex_clipped (req_vertex_clipped),
      .req_pos_x_bits     (req_pos_x_bits),
      .req_pos_y_bits     (req_pos_y_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_corner_a       (rsp_corner_a),
      .rsp_corner_b       (rsp_corner_b),
      .rsp_corner_c       (rsp_corner_c),
      .rsp_is_line        (rsp_is_line),
      .rsp_last_of_run    (rsp_last_of_run),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // ---------------------------------------------------------------------
   // Book-keeping shared by the tests, the receiver and the checker
   // ---------------------------------------------------------------------
   prim_type pending_prims[$];  // primitives predicted but not yet seen
   prim_type new_prims[$];      // built by the transaction being predicted
   int      failures       = 0;
   int      prims_checked  = 0;
   int      items_sent     = 0; // every accepted transaction
   int      vertices_sent  = 0; // vertices the block actually assembles
   int      ends_sent      = 0;
   int      settings_used  = 0;
   int      cycle_count    = 0;
   bit      steady         = 1'b0; // both sides run flat out while set
   int      hold_request   = 0;    // receiver hold-off asked for by a test

   // ---------------------------------------------------------------------
   // Predictor state: register shadows and assembly state
   // ---------------------------------------------------------------------
   logic [3:0]    cfg_topology    = TOPO_TRILIST;
   logic [1:0]    cfg_strip_prov  = '0;
   logic [1:0]    cfg_fan_prov    = '0;

   handle_type    win_handle  [WIN_DEPTH];
   logic          win_clipped [WIN_DEPTH];
   logic [31:0]   win_x       [WIN_DEPTH];
   logic [31:0]   win_y       [WIN_DEPTH];
   int            win_fill       = 0;
   handle_type    anchor_handle  = '0;
   logic          anchor_clipped = 1'b0;
   logic          anchor_held    = 1'b0;
   int            strip_odd      = 0;

   // Triangle with provoking rotation and winding; the corner order is the
   // provoking index then the other two taken modulo three, swapped when odd.
   function automatic void add_triangle(handle_type h0, handle_type h1, handle_type h2,
                                        logic k0, logic k1, logic k2,
                                        int prov, int odd);
      handle_type h[3];
      int         p;
      if (k0 | k1 | k2)
         return;
      h[0] = h0;
      h[1] = h1;
      h[2] = h2;
      p = (prov > 2) ? 2 : prov;
      new_prims.push_back('{h[p], h[(p + 1 + odd) % 3], h[(p + 2 - odd) % 3],
                            1'b0, 1'b0});
   endfunction

   function automatic void add_line(handle_type h0, logic k0, handle_type h1, logic k1);
      if (k0 | k1)
         return;
      new_prims.push_back('{h0, h1, 16'h0, 1'b1, 1'b0});
   endfunction

   function automatic void window_triangle(int i, int j, int k, int prov, int odd);
      add_triangle(win_handle[i], win_handle[j], win_handle[k],
                   win_clipped[i], win_clipped[j], win_clipped[k], prov, odd);
   endfunction

   function automatic void drop_window(int count);
      if (count >= win_fill) begin
         win_fill = 0;
         return;
      end
      for (int i = 0; i + count < win_fill; i++) begin
         win_handle[i]  = win_handle[i + count];
         win_clipped[i] = win_clipped[i + count];
         win_x[i]       = win_x[i + count];
         win_y[i]       = win_y[i + count];
      end
      win_fill -= count;
   endfunction

   // rect lists: rotate so that the first edge that is diagonal runs from the last corner to the first
   function automatic int rect_turn();
      if (win_x[0] != win_x[1] && win_y[0] != win_y[1])
         return 1;
      if (win_x[1] != win_x[2] && win_y[1] != win_y[2])
         return 2;
      return 0;
   endfunction

   // Updates the assembly state for one accepted transaction and queues the
   // primitives it makes. Returns 1 when a vertex was actually assembled.
   function automatic int assemble(logic kind, handle_type h, logic cl,
                                   logic [31:0] x, logic [31:0] y);
      int used;
      bit anchor_only;
      used = 0;
      anchor_only = 1'b0;
      new_prims.delete();
      if (kind == KIND_END) begin
         // end of instance closes an open loop, then starts afresh
         if (cfg_topology == TOPO_LINELOOP && win_fill == 1 && anchor_held)
            add_line(win_handle[0], win_clipped[0], anchor_handle, anchor_clipped);
         win_fill       = 0;
         anchor_handle  = '0;
         anchor_clipped = 1'b0;
         anchor_held    = 1'b0;
         strip_odd      = 0;
      end else if (cfg_topology <= TOPO_LINELOOP) begin
         used = 1;
         // first vertex of a fan, polygon or loop becomes the anchor; only
         // the loop also pushes it into the window
         if (!anchor_held && (cfg_topology == TOPO_TRIFAN ||
                              cfg_topology == TOPO_POLYGON ||
                              cfg_topology == TOPO_LINELOOP)) begin
            anchor_handle  = h;
            anchor_clipped = cl;
            anchor_held    = 1'b1;
            anchor_only    = (cfg_topology != TOPO_LINELOOP);
         end
         if (!anchor_only) begin
            if (win_fill >= WIN_DEPTH)
               drop_window(1);
            win_handle[win_fill]  = h;
            win_clipped[win_fill] = cl;
            win_x[win_fill]       = x;
            win_y[win_fill]       = y;
            win_fill++;
            case (cfg_topology)
               TOPO_TRILIST: begin
                  if (win_fill >= 3) begin
                     window_triangle(0, 1, 2, cfg_strip_prov, 0);
                     drop_window(3);
                  end
               end
               TOPO_TRISTRIP: begin
                  if (win_fill >= 3) begin
                     window_triangle(0, 1, 2, cfg_strip_prov, strip_odd);
                     strip_odd ^= 1;  // toggles on dropped triangles as well
                     drop_window(1);
                  end
               end
               TOPO_TRIFAN, TOPO_POLYGON: begin
                  if (win_fill >= 2) begin
                     add_triangle(anchor_handle, win_handle[0], win_handle[1],
                                  anchor_clipped, win_clipped[0], win_clipped[1],
                                  (cfg_topology == TOPO_TRIFAN) ? cfg_fan_prov : 0,
                                  strip_odd);
                     drop_window(1);
                  end
               end
               TOPO_QUADLIST: begin
                  if (win_fill >= 4) begin
                     window_triangle(3, 0, 1, 0, 0);
                     window_triangle(3, 1, 2, 0, 0);
                     drop_window(4);
                  end
               end
               TOPO_QUADSTRIP: begin
                  if (win_fill >= 4) begin
                     window_triangle(3, 0, 1, 0, 0);
                     window_triangle(3, 2, 0, 0, 0);
                     drop_window(2);
                  end
               end
               TOPO_RECTLIST: begin
                  if (win_fill >= 3) begin
                     window_triangle(0, 1, 2, rect_turn(), 0);
                     drop_window(3);
                  end
               end
               TOPO_LINELIST, TOPO_LINESTRIP, TOPO_LINELOOP: begin
                  if (win_fill >= 2) begin
                     add_line(win_handle[0], win_clipped[0],
                              win_handle[1], win_clipped[1]);
                     drop_window((cfg_topology == TOPO_LINELIST) ? 2 : 1);
                  end
               end
               default: ;
            endcase
         end
      end
      if (new_prims.size() > 0)
         new_prims[new_prims.size() - 1].last_of_run = 1'b1;
      foreach (new_prims[i])
         pending_prims.push_back(new_prims[i]);
      return used;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      static int hold_left = 0;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: each accepted result against the oldest prediction
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%h, got 0x%h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      prim_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_prims.size() == 0) begin
            $error("primitive with nothing predicted: a=0x%h b=0x%h c=0x%h line=%b",
                   rsp_corner_a, rsp_corner_b, rsp_corner_c, rsp_is_line);
            failures++;
         end else begin
            want = pending_prims.pop_front();
            check_field("corner_a",    want.corner_a,    rsp_corner_a);
            check_field("corner_b",    want.corner_b,    rsp_corner_b);
            check_field("corner_c",    want.corner_c,    rsp_corner_c);
            check_field("is_line",     want.is_line,     rsp_is_line);
            check_field("last_of_run", want.last_of_run, rsp_last_of_run);
            prims_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** primitive_assembler: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offers one transaction and returns at the edge that accepts it. Valid is
   // left high so that back-to-back transactions need no extra assignment.
   task automatic send_item(logic kind, handle_type h, logic cl, logic [31:0] x,
                            logic [31:0] y);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_kind           <= kind;
      req_vertex_handle  <= h;
      req_vertex_clipped <= cl;
      req_pos_x_bits     <= x;
      req_pos_y_bits     <= y;
      req_valid          <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      vertices_sent += assemble(kind, h, cl, x, y);
      if (kind == KIND_END)
         ends_sent++;
   endtask

   task automatic send_vertex(handle_type h, logic cl, logic [31:0] x, logic [31:0] y);
      send_item(KIND_VERTEX, h, cl, x, y);
   endtask

   // other fields of an end marker are ignored, so they carry noise
   task automatic send_end();
      send_item(KIND_END, handle_type'($urandom_range(0, 16'hFFFF)),
                1'($urandom_range(0, 1)), $urandom, $urandom);
   endtask

   // Drops valid and waits until every predicted primitive has come back or DRAIN_LIMIT runs out.
   task automatic hold_sender();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_prims.size() != 0 && waited < DRAIN_LIMIT);
   endtask

   // Idle point for register writes: an item that made no primitive may still
   // be in flight, so a quiet wait follows the drain.
   task automatic settle();
      hold_sender();
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Back-to-back APB writes of all three registers; psel stays up between
   // them so that no signal is assigned twice in one step.
   task automatic configure(logic [3:0] topo, logic [1:0] strip_prov, logic [1:0] fan_prov);
      logic [1:0]  regs [3];
      logic [31:0] vals [3];
      regs = '{REG_TOPOLOGY, REG_STRIP_PROVOKING, REG_FAN_PROVOKING};
      vals = '{{28'h0, topo}, {30'h0, strip_prov}, {30'h0, fan_prov}};
      for (int i = 0; i < 3; i++) begin
         psel    <= 1'b1;
         pwrite  <= 1'b1;
         penable <= 1'b0;
         paddr   <= {regs[i], 2'b00};
         pwdata  <= vals[i];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_topology   = topo;
      cfg_strip_prov = strip_prov;
      cfg_fan_prov   = fan_prov;
      settings_used++;
   endtask

   // positions from a small pool so that rect lists see equal coordinates
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h3F80_0000;
         default: return $urandom;
      endcase
   endfunction

   // n vertices of one instance, with the odd stray end marker as noise
   task automatic run_instance(int n);
      repeat (n) begin
         if ($urandom_range(0, 99) < 4)
            send_end();
         send_vertex(handle_type'($urandom_range(0, 16'hFFFF)),
                     $urandom_range(0, 99) < CLIP_PERCENT,
                     pick_coord(), pick_coord());
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short hand-written cases: field extremes, saturated provoking index,
   // clip drop, both rect reorderings, loop closure, two-triangle quads and
   // an unused topology code.
   task automatic test_corner_cases();
      configure(TOPO_TRILIST, 2'd3, 2'd0);
      send_vertex(16'h0000, 1'b0, 32'h0000_0000, 32'h0000_0000);
      send_vertex(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(16'h1234, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_vertex(16'h0001, 1'b0, 32'h1, 32'h1);
      send_vertex(16'h0002, 1'b1, 32'h2, 32'h2);   // clipped: triangle dropped
      send_vertex(16'h0003, 1'b0, 32'h3, 32'h3);
      settle();

      configure(TOPO_RECTLIST, 2'd0, 2'd0);
      send_vertex(16'h0010, 1'b0, 32'h0, 32'h0);   // first edge diagonal
      send_vertex(16'h0011, 1'b0, 32'h1, 32'h1);
      send_vertex(16'h0012, 1'b0, 32'h1, 32'h0);
      send_vertex(16'h0020, 1'b0, 32'h5, 32'h0);   // diagonal edge from the middle corner to the last
      send_vertex(16'h0021, 1'b0, 32'h5, 32'h7);
      send_vertex(16'h0022, 1'b0, 32'h9, 32'h9);
      settle();

      configure(TOPO_LINELOOP, 2'd0, 2'd0);
      send_vertex(16'h0100, 1'b0, 32'h0, 32'h0);
      send_vertex(16'h0101, 1'b0, 32'h0, 32'h0);
      send_vertex(16'h0102, 1'b0, 32'h0, 32'h0);
      send_end();                                  // closes back to the anchor
      settle();

      configure(TOPO_QUADLIST, 2'd0, 2'd0);
      send_vertex(16'h0200, 1'b0, 32'h0, 32'h0);
      send_vertex(16'h0201, 1'b0, 32'h0, 32'h0);
      send_vertex(16'h0202, 1'b0, 32'h0, 32'h0);
      send_vertex(16'h0203, 1'b0, 32'h0, 32'h0);
      settle();

      configure(TOPO_UNUSED_TOP, 2'd3, 2'd3);
      send_vertex(16'hAAAA, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
      send_vertex(16'h5555, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
      send_end();
      settle();
   endtask

   // A long stretch with no idling on either side.
   task automatic test_streaming();
      configure(TOPO_TRISTRIP, 2'd1, 2'd2);
      steady = 1'b1;
      repeat (10) begin
         run_instance(15);
         send_end();
      end
      steady = 1'b0;
      settle();
   endtask

   // Receiver holds off for a long stretch while quads keep arriving, so the
   // result queue fills and the input is stalled.
   task automatic test_backpressure();
      configure(TOPO_QUADLIST, 2'd0, 2'd0);
      steady       = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (48)
         send_vertex(handle_type'($urandom_range(0, 16'hFFFF)), 1'b0, $urandom, $urandom);
      steady = 1'b0;
      settle();
   endtask

   // Random settings, each with several instances of random
   // length; some instances stay open across a register change, and now and
   // then the sender pauses until every primitive has come back.
   task automatic test_random_phases();
      logic [3:0] topo;
      while (items_sent < ITEM_TARGET) begin
         topo = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
         configure(topo, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         repeat ($urandom_range(2, 6)) begin
            run_instance($urandom_range(1, 14));
            if ($urandom_range(0, 99) < 80)
               send_end();
            if ($urandom_range(0, 99) < 15)
               hold_sender();
         end
         settle();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_streaming();
      test_backpressure();
      test_random_phases();

      hold_sender();
      repeat (16) @(posedge clock);
      if (pending_prims.size() != 0) begin
         $error("%0d predicted primitives never arrived", pending_prims.size());
         failures++;
      end

      $display("Sent %0d transactions (%0d assembled vertices, %0d end markers) over %0d register settings.",
               items_sent, vertices_sent, ends_sent, settings_used);
      $display("Checked %0d primitives; %0d mismatches.", prims_checked, failures);
      if (failures == 0)
         $display("** primitive_assembler: PASSED **");
      else
         $display("** primitive_assembler: FAILED **");
      $finish;
   end

endmodule

### primitive_assembler.f
rtl/pa_pkg.sv
rtl/pa_out_fifo.sv
rtl/primitive_assembler.sv
test/primitive_assembler_test.sv
